// ===== sv/tms_pkg.sv =====
package tms_pkg;

  localparam int TAPE_DEPTH_DEF = 4096;
  localparam int NUM_STATES_DEF = 64;
  localparam int SYMBOLS        = 256;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_RESTART = 3'd2,
    REQ_READ    = 3'd3,
    REQ_RUN     = 3'd4
  } tms_req_e;

  typedef enum logic [1:0] {
    CFG_INITIAL = 2'd0,
    CFG_ACCEPT  = 2'd1,
    CFG_REJECT  = 2'd2,
    CFG_BLANK   = 2'd3
  } tms_cfg_idx_e;

  typedef enum logic [1:0] {
    STAT_RUNNING  = 2'd0,
    STAT_ACCEPTED = 2'd1,
    STAT_REJECTED = 2'd2,
    STAT_OVERFLOW = 2'd3
  } tms_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FILL,
    S_CELL_WR,
    S_STEP,
    S_TAPE_WAIT,
    S_EXEC,
    S_REPORT,
    S_DONE
  } tms_state_e;

  localparam logic [5:0] INITIAL_RST = 6'd0;
  localparam logic [5:0] ACCEPT_RST  = 6'd1;
  localparam logic [5:0] REJECT_RST  = 6'd2;
  localparam logic [7:0] BLANK_RST   = 8'd32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  from_state;
    logic [7:0]  read_symbol_key;
    logic [5:0]  next_state;
    logic [7:0]  write_symbol;
    logic        move_left;
    logic [11:0] move_length;
    logic [11:0] cell_index;
    logic [7:0]  cell_symbol;
    logic [15:0] step_count;
  } tms_in_t;

  typedef struct packed {
    logic [7:0]  symbol_out;
    logic [5:0]  machine_state;
    logic [11:0] head_position;
    logic [1:0]  status;
  } tms_out_t;

  typedef struct packed {
    logic [11:0] move_length;
    logic        move_left;
    logic [7:0]  write_symbol;
    logic [5:0]  next_state;
  } tms_entry_t;

  typedef struct packed {
    logic [5:0] initial_state;
    logic [5:0] accept_state;
    logic [5:0] reject_state;
    logic [7:0] blank_symbol;
  } tms_cfg_t;

endpackage

// ===== sv/turing_machine_stepper.sv =====
// load, restart, read, unknown items and writes out of range pass through dispatch, report
// and done before the result is registered; a tape write adds a blank fill and a cell write
// run: each step passes through step (tape read), tape wait (table read) and exec (write and
// head move), with a blank fill whenever the tape grows; entry, final growth and report close it
// items: one at a time, the next transfer in taken in the cycle after its result is registered
// reset: table clearing pass over all NUM_STATES*256 entries with input stalled; state 0, head 0, no tape
module turing_machine_stepper #(
  parameter int TAPE_DEPTH = tms_pkg::TAPE_DEPTH_DEF,
  parameter int NUM_STATES = tms_pkg::NUM_STATES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tms_pkg::tms_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tms_pkg::tms_out_t out_data_o
);
  import tms_pkg::*;

  localparam int HW  = $clog2(TAPE_DEPTH);
  localparam int TAW = $clog2(NUM_STATES * SYMBOLS);

  tms_cfg_t cfg_q, cfg_d;
  logic     out_valid_q, out_valid_d;
  tms_out_t out_data_q;

  logic           clr_busy;
  logic           table_we, table_re;
  logic [TAW-1:0] table_waddr, table_raddr;
  tms_entry_t     table_wdata, table_rdata;
  logic           tape_we, tape_re;
  logic [HW-1:0]  tape_waddr, tape_raddr;
  logic [7:0]     tape_wdata, tape_rdata;
  logic           res_valid, res_ready;
  tms_out_t       res_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INITIAL: cfg_d.initial_state = cfg_data_i[5:0];
        CFG_ACCEPT:  cfg_d.accept_state  = cfg_data_i[5:0];
        CFG_REJECT:  cfg_d.reject_state  = cfg_data_i[5:0];
        CFG_BLANK:   cfg_d.blank_symbol  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // output register lets the sequencer finish while the sink stalls
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_state <= INITIAL_RST;
      cfg_q.accept_state  <= ACCEPT_RST;
      cfg_q.reject_state  <= REJECT_RST;
      cfg_q.blank_symbol  <= BLANK_RST;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tms_table #(
    .NUM_STATES(NUM_STATES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (table_we),
    .waddr_i(table_waddr),
    .wdata_i(table_wdata),
    .re_i   (table_re),
    .raddr_i(table_raddr),
    .rdata_o(table_rdata),
    .busy_o (clr_busy)
  );

  tms_tape #(
    .TAPE_DEPTH(TAPE_DEPTH)
  ) u_tape (
    .clk_i  (clk_i),
    .we_i   (tape_we),
    .waddr_i(tape_waddr),
    .wdata_i(tape_wdata),
    .re_i   (tape_re),
    .raddr_i(tape_raddr),
    .rdata_o(tape_rdata)
  );

  tms_ctrl #(
    .TAPE_DEPTH(TAPE_DEPTH),
    .NUM_STATES(NUM_STATES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_i        (cfg_q),
    .clr_busy_i   (clr_busy),
    .table_we_o   (table_we),
    .table_waddr_o(table_waddr),
    .table_wdata_o(table_wdata),
    .table_re_o   (table_re),
    .table_raddr_o(table_raddr),
    .table_rdata_i(table_rdata),
    .tape_we_o    (tape_we),
    .tape_waddr_o (tape_waddr),
    .tape_wdata_o (tape_wdata),
    .tape_re_o    (tape_re),
    .tape_raddr_o (tape_raddr),
    .tape_rdata_i (tape_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_o   (res_data)
  );

endmodule

// ===== sv/tms_table.sv =====
module tms_table #(
  parameter int NUM_STATES = tms_pkg::NUM_STATES_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        we_i,
  input  logic [$clog2(NUM_STATES*tms_pkg::SYMBOLS)-1:0] waddr_i,
  input  tms_pkg::tms_entry_t                         wdata_i,
  input  logic                                        re_i,
  input  logic [$clog2(NUM_STATES*tms_pkg::SYMBOLS)-1:0] raddr_i,
  output tms_pkg::tms_entry_t                         rdata_o,
  output logic                                        busy_o
);
  import tms_pkg::*;

  localparam int TD  = NUM_STATES * SYMBOLS;
  localparam int TAW = $clog2(TD);

  tms_entry_t mem [TD];
  tms_entry_t rdata_q;

  logic           clr_busy_q, clr_busy_d;
  logic [TAW-1:0] clr_addr_q, clr_addr_d;

  // clearing pass after reset, one entry per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == TAW'(TD - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + TAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

// ===== sv/tms_tape.sv =====
module tms_tape #(
  parameter int TAPE_DEPTH = tms_pkg::TAPE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(TAPE_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(TAPE_DEPTH)-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);
  logic [7:0] mem [TAPE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tms_ctrl.sv =====
module tms_ctrl #(
  parameter int TAPE_DEPTH = tms_pkg::TAPE_DEPTH_DEF,
  parameter int NUM_STATES = tms_pkg::NUM_STATES_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  tms_pkg::tms_in_t                            in_data_i,
  input  tms_pkg::tms_cfg_t                           cfg_i,
  input  logic                                        clr_busy_i,
  output logic                                        table_we_o,
  output logic [$clog2(NUM_STATES*tms_pkg::SYMBOLS)-1:0] table_waddr_o,
  output tms_pkg::tms_entry_t                         table_wdata_o,
  output logic                                        table_re_o,
  output logic [$clog2(NUM_STATES*tms_pkg::SYMBOLS)-1:0] table_raddr_o,
  input  tms_pkg::tms_entry_t                         table_rdata_i,
  output logic                                        tape_we_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]               tape_waddr_o,
  output logic [7:0]                                  tape_wdata_o,
  output logic                                        tape_re_o,
  output logic [$clog2(TAPE_DEPTH)-1:0]               tape_raddr_o,
  input  logic [7:0]                                  tape_rdata_i,
  output logic                                        res_valid_o,
  input  logic                                        res_ready_i,
  output tms_pkg::tms_out_t                           res_data_o
);
  import tms_pkg::*;

  localparam int HW  = $clog2(TAPE_DEPTH);
  localparam int LW  = $clog2(TAPE_DEPTH + 1);
  localparam int TAW = $clog2(NUM_STATES * SYMBOLS);
  localparam int SIW = TAW - 8;
  localparam int SXW = (SIW > 6) ? SIW : 6;
  localparam int CXW = (HW > 12) ? HW : 12;
  localparam int AW  = CXW + 1;

  tms_state_e  state_q, state_d;
  tms_state_e  ret_q, ret_d;
  tms_in_t     item_q, item_d;
  logic [5:0]  cur_q, cur_d;
  logic [HW-1:0] head_q, head_d;
  logic [LW-1:0] tlen_q, tlen_d;
  logic        ovf_q, ovf_d;
  logic [15:0] steps_q, steps_d;
  logic [HW-1:0] fill_tgt_q, fill_tgt_d;
  logic        hit_q, hit_d;

  logic [CXW-1:0] cidx_ext;
  logic [HW-1:0]  cidx_addr;
  logic           cidx_ok, from_ok, cur_ok;
  logic [SXW-1:0] from_ext, cur_ext;
  logic [TAW-1:0] load_addr, step_addr;
  logic           halted, head_in_tape, cidx_in_tape, fill_more, run_done;
  tms_entry_t     entry;
  logic [AW-1:0]  head_x, len_x, op_b, move_res;
  logic           left_clamp, right_ovf;
  logic           is_read;

  assign cidx_ext  = CXW'(item_q.cell_index);
  assign cidx_addr = cidx_ext[HW-1:0];
  assign cidx_ok   = 32'(item_q.cell_index) < TAPE_DEPTH;
  assign from_ok   = 32'(item_q.from_state) < NUM_STATES;
  assign cur_ok    = 32'(cur_q) < NUM_STATES;
  assign from_ext  = SXW'(item_q.from_state);
  assign cur_ext   = SXW'(cur_q);
  assign load_addr = {from_ext[SIW-1:0], item_q.read_symbol_key};
  assign step_addr = {cur_ext[SIW-1:0], tape_rdata_i};

  assign halted       = ovf_q || (cur_q == cfg_i.accept_state) ||
                        (cur_q == cfg_i.reject_state);
  assign run_done     = (steps_q == 16'd0) || halted;
  assign head_in_tape = 32'(head_q) < 32'(tlen_q);
  assign cidx_in_tape = cidx_ok && (32'(item_q.cell_index) < 32'(tlen_q));
  assign fill_more    = 32'(tlen_q) <= 32'(fill_tgt_q);
  assign is_read      = item_q.req_type == REQ_READ;

  // out-of-range state behaves as an undefined entry
  assign entry = cur_ok ? table_rdata_i : '0;

  // shared head move adder: add for right moves, subtract for left moves
  assign head_x     = AW'(head_q);
  assign len_x      = AW'(entry.move_length);
  assign op_b       = entry.move_left ? ~len_x : len_x;
  assign move_res   = head_x + op_b + AW'(entry.move_left);
  assign left_clamp = move_res[AW-1] || (move_res == '0);
  assign right_ovf  = move_res >= AW'(TAPE_DEPTH);

  // next state and register updates
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    item_d     = item_q;
    cur_d      = cur_q;
    head_d     = head_q;
    tlen_d     = tlen_q;
    ovf_d      = ovf_q;
    steps_d    = steps_q;
    fill_tgt_d = fill_tgt_q;
    hit_d      = hit_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !clr_busy_i) begin
          item_d  = in_data_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (item_q.req_type)
          REQ_WRITE: begin
            if (cidx_ok) begin
              fill_tgt_d = cidx_addr;
              ret_d      = S_CELL_WR;
              state_d    = S_FILL;
            end else begin
              state_d = S_REPORT;
            end
          end
          REQ_RESTART: begin
            cur_d   = cfg_i.initial_state;
            head_d  = '0;
            tlen_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_REPORT;
          end
          REQ_RUN: begin
            steps_d = item_q.step_count;
            state_d = S_STEP;
          end
          default: state_d = S_REPORT;
        endcase
      end
      S_FILL: begin
        if (fill_more) begin
          tlen_d = tlen_q + LW'(1);
        end else begin
          state_d = ret_q;
        end
      end
      S_CELL_WR: state_d = S_REPORT;
      S_STEP: begin
        if (run_done) begin
          // grow the tape up to the final head cell
          fill_tgt_d = head_q;
          ret_d      = S_REPORT;
          state_d    = S_FILL;
        end else if (!head_in_tape) begin
          fill_tgt_d = head_q;
          ret_d      = S_STEP;
          state_d    = S_FILL;
        end else begin
          state_d = S_TAPE_WAIT;
        end
      end
      S_TAPE_WAIT: state_d = S_EXEC;
      S_EXEC: begin
        steps_d = steps_q - 16'd1;
        if (entry.write_symbol == 8'd0) begin
          cur_d = cfg_i.reject_state;
        end else begin
          cur_d = entry.next_state;
          if (entry.move_left) begin
            head_d = left_clamp ? '0 : move_res[HW-1:0];
          end else if (right_ovf) begin
            ovf_d = 1'b1;
          end else begin
            head_d = move_res[HW-1:0];
          end
        end
        state_d = S_STEP;
      end
      S_REPORT: begin
        hit_d   = is_read ? cidx_in_tape : head_in_tape;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory ports and handshake
  always_comb begin
    in_stall_o                 = (state_q != S_IDLE) || clr_busy_i;
    table_we_o                 = 1'b0;
    table_waddr_o              = load_addr;
    table_wdata_o.move_length  = item_q.move_length;
    table_wdata_o.move_left    = item_q.move_left;
    table_wdata_o.write_symbol = item_q.write_symbol;
    table_wdata_o.next_state   = item_q.next_state;
    table_re_o                 = 1'b0;
    table_raddr_o              = step_addr;
    tape_we_o                  = 1'b0;
    tape_waddr_o               = head_q;
    tape_wdata_o               = entry.write_symbol;
    tape_re_o                  = 1'b0;
    tape_raddr_o               = head_q;
    res_valid_o                = 1'b0;
    case (state_q)
      S_DISPATCH: begin
        table_we_o = (item_q.req_type == REQ_LOAD) && from_ok;
      end
      S_FILL: begin
        if (fill_more) begin
          tape_we_o    = 1'b1;
          tape_waddr_o = tlen_q[HW-1:0];
          tape_wdata_o = cfg_i.blank_symbol;
        end
      end
      S_CELL_WR: begin
        tape_we_o    = 1'b1;
        tape_waddr_o = cidx_addr;
        tape_wdata_o = item_q.cell_symbol;
      end
      S_STEP: begin
        tape_re_o = !run_done && head_in_tape;
      end
      S_TAPE_WAIT: begin
        table_re_o = 1'b1;
      end
      S_EXEC: begin
        tape_we_o = entry.write_symbol != 8'd0;
      end
      S_REPORT: begin
        tape_re_o    = 1'b1;
        tape_raddr_o = is_read ? cidx_addr : head_q;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_data_o.symbol_out    = hit_q ? tape_rdata_i : cfg_i.blank_symbol;
    res_data_o.machine_state = cur_q;
    res_data_o.head_position = 12'(head_q);
    if (ovf_q) begin
      res_data_o.status = STAT_OVERFLOW;
    end else if (cur_q == cfg_i.accept_state) begin
      res_data_o.status = STAT_ACCEPTED;
    end else if (cur_q == cfg_i.reject_state) begin
      res_data_o.status = STAT_REJECTED;
    end else begin
      res_data_o.status = STAT_RUNNING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_REPORT;
      cur_q   <= '0;
      head_q  <= '0;
      tlen_q  <= '0;
      ovf_q   <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cur_q   <= cur_d;
      head_q  <= head_d;
      tlen_q  <= tlen_d;
      ovf_q   <= ovf_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    fill_tgt_q <= fill_tgt_d;
    hit_q      <= hit_d;
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tms_pkg::*;

  localparam int TAPE_CELLS    = TAPE_DEPTH_DEF;
  localparam int STATE_COUNT   = NUM_STATES_DEF;
  localparam int RANDOM_ITEMS  = 440;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int TAIL_CYCLES   = 50;
  // request codes the block does not know
  localparam logic [2:0] REQ_BAD_FIRST = 3'd5;
  localparam logic [2:0] REQ_BAD_LAST  = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic     in_valid_i;
  logic     in_stall_o;
  tms_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tms_out_t out_data_o;

  turing_machine_stepper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // machine mirror
  tms_cfg_t    cfg;
  tms_entry_t  trans_tbl [STATE_COUNT * SYMBOLS];
  logic [7:0]  tape_mem [TAPE_CELLS];
  logic [5:0]  cur_state;
  int unsigned head_pos;
  int unsigned tape_len;
  bit          ovf;

  tms_out_t expected_reports [$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       hold_cycles = 0;
  bit       steady_input = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void reset_machine_model();
    for (int i = 0; i < STATE_COUNT * SYMBOLS; i++) trans_tbl[i] = '0;
    cfg = '{initial_state: INITIAL_RST, accept_state: ACCEPT_RST,
            reject_state: REJECT_RST, blank_symbol: BLANK_RST};
    cur_state = '0;
    head_pos  = 0;
    tape_len  = 0;
    ovf       = 1'b0;
  endfunction

  function automatic void extend_tape(int unsigned idx);
    while (tape_len <= idx && tape_len < TAPE_CELLS) begin
      tape_mem[tape_len] = cfg.blank_symbol;
      tape_len++;
    end
  endfunction

  function automatic logic [7:0] cell_value(int unsigned idx);
    if (idx >= TAPE_CELLS || idx >= tape_len) return cfg.blank_symbol;
    return tape_mem[idx];
  endfunction

  function automatic bit machine_halted();
    return ovf || cur_state == cfg.accept_state || cur_state == cfg.reject_state;
  endfunction

  function automatic void take_step();
    logic [7:0] sym;
    tms_entry_t ent;
    extend_tape(head_pos);
    sym = cell_value(head_pos);
    ent = trans_tbl[cur_state * SYMBOLS + sym];
    // a zero write symbol marks the entry as undefined
    if (ent.write_symbol == '0) begin
      cur_state = cfg.reject_state;
      return;
    end
    cur_state = ent.next_state;
    tape_mem[head_pos] = ent.write_symbol;
    if (ent.move_left) begin
      head_pos = (ent.move_length >= head_pos) ? 0 : head_pos - ent.move_length;
    end else if (head_pos + ent.move_length >= TAPE_CELLS) begin
      ovf = 1'b1;
    end else begin
      head_pos = head_pos + ent.move_length;
    end
  endfunction

  function automatic tms_out_t apply_request(tms_in_t item);
    tms_out_t    res;
    int unsigned n;
    case (item.req_type)
      REQ_LOAD: begin
        if (item.from_state < STATE_COUNT)
          trans_tbl[item.from_state * SYMBOLS + item.read_symbol_key] = '{
            move_length: item.move_length, move_left: item.move_left,
            write_symbol: item.write_symbol, next_state: item.next_state};
      end
      REQ_WRITE: begin
        if (item.cell_index < TAPE_CELLS) begin
          extend_tape(32'(item.cell_index));
          tape_mem[item.cell_index] = item.cell_symbol;
        end
      end
      REQ_RESTART: begin
        cur_state = cfg.initial_state;
        head_pos  = 0;
        tape_len  = 0;
        ovf       = 1'b0;
      end
      REQ_RUN: begin
        n = 0;
        while (n < item.step_count && !machine_halted()) begin
          take_step();
          n++;
        end
        extend_tape(head_pos);
      end
      default: ;
    endcase
    res.symbol_out    = (item.req_type == REQ_READ) ? cell_value(32'(item.cell_index))
                                                    : cell_value(head_pos);
    res.machine_state = cur_state;
    res.head_position = 12'(head_pos);
    if (ovf) res.status = STAT_OVERFLOW;
    else if (cur_state == cfg.accept_state) res.status = STAT_ACCEPTED;
    else if (cur_state == cfg.reject_state) res.status = STAT_REJECTED;
    else res.status = STAT_RUNNING;
    return res;
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    tms_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("symbol_out", 12'(want.symbol_out), 12'(out_data_o.symbol_out));
        check_field("machine_state", 12'(want.machine_state),
                    12'(out_data_o.machine_state));
        check_field("head_position", want.head_position, out_data_o.head_position);
        check_field("status", 12'(want.status), 12'(out_data_o.status));
      end
    end
  end

  // receiver side: random stalls, long free stretches, and a counted hold-off on request
  initial begin : out_stall_gen
    int busy_left;
    int free_left;
    int r;
    busy_left   = 0;
    free_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (busy_left > 0) begin
        out_stall_i <= 1'b1;
        busy_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (free_left > 0) begin
          free_left--;
        end else begin
          r = $urandom_range(0, 99);
          busy_left = r < 70 ? 0 : r < 92 ? $urandom_range(1, 3) :
                      r < 98 ? $urandom_range(4, 12) : $urandom_range(20, 60);
          free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 6);
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] pick_move();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 12'($urandom_range(0, 2));
    if (r < 9) return 12'($urandom_range(3, 30));
    return 12'($urandom);
  endfunction

  function automatic logic [11:0] pick_cell();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return 12'($urandom_range(0, 15));
    if (r < 19) return 12'($urandom_range(0, 200));
    return 12'($urandom);
  endfunction

  // full 16-bit counts only once the machine is halted, so no step is taken
  function automatic logic [15:0] pick_steps();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) return 16'($urandom_range(0, 25));
    if (r < 19 || !machine_halted()) return 16'($urandom_range(26, 400));
    return 16'($urandom);
  endfunction

  function automatic tms_in_t random_item(logic [2:0] req);
    logic [95:0] raw;
    tms_in_t     item;
    raw  = {$urandom, $urandom, $urandom};
    item = raw[$bits(tms_in_t)-1:0];
    item.req_type = req;
    return item;
  endfunction

  task automatic send_request(input tms_in_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_reports = {expected_reports, apply_request(item)};
    if (item.req_type <= REQ_RUN) items_sent++;
    gap = steady_input ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tms_cfg_idx_e idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_INITIAL: cfg.initial_state = value[5:0];
      CFG_ACCEPT:  cfg.accept_state  = value[5:0];
      CFG_REJECT:  cfg.reject_state  = value[5:0];
      CFG_BLANK:   cfg.blank_symbol  = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [5:0] init_st, input logic [5:0] acc_st,
                                input logic [5:0] rej_st, input logic [7:0] blank);
    drain_results();
    write_reg(CFG_INITIAL, {2'($urandom), init_st});
    write_reg(CFG_ACCEPT, {2'($urandom), acc_st});
    write_reg(CFG_REJECT, {2'($urandom), rej_st});
    write_reg(CFG_BLANK, blank);
  endtask

  task automatic send_simple(input logic [2:0] req, input logic [11:0] cell_idx,
                             input logic [7:0] sym, input logic [15:0] steps);
    tms_in_t item;
    item = random_item(req);
    item.cell_index  = cell_idx;
    item.cell_symbol = sym;
    item.step_count  = steps;
    send_request(item);
  endtask

  task automatic send_entry(input logic [5:0] from_st, input logic [7:0] key,
                            input logic [5:0] next_st, input logic [7:0] wsym,
                            input logic left, input logic [11:0] len);
    tms_in_t item;
    item = random_item(REQ_LOAD);
    item.from_state      = from_st;
    item.read_symbol_key = key;
    item.next_state      = next_st;
    item.write_symbol    = wsym;
    item.move_left       = left;
    item.move_length     = len;
    send_request(item);
  endtask

  // small machine over a few states and symbols so that lookups hit loaded entries
  task automatic run_program();
    logic [7:0] syms [3];
    logic [5:0] states [5];
    tms_in_t    item;
    steady_input = ($urandom_range(0, 4) == 0);
    syms[0]   = cfg.blank_symbol;
    syms[1]   = 8'($urandom);
    syms[2]   = 8'($urandom);
    states[0] = cfg.initial_state;
    states[1] = 6'($urandom);
    states[2] = 6'($urandom);
    states[3] = cfg.accept_state;
    states[4] = cfg.reject_state;
    repeat ($urandom_range(2, 8)) begin
      item = random_item(REQ_LOAD);
      item.from_state      = states[$urandom_range(0, 2)];
      item.read_symbol_key = syms[$urandom_range(0, 2)];
      item.next_state      = states[$urandom_range(0, 4)];
      item.write_symbol    = ($urandom_range(0, 11) == 0) ? 8'd0 : syms[$urandom_range(0, 2)];
      item.move_length     = pick_move();
      send_request(item);
    end
    if ($urandom_range(0, 3) != 0) send_request(random_item(REQ_RESTART));
    repeat ($urandom_range(0, 5))
      send_simple(REQ_WRITE, pick_cell(), syms[$urandom_range(0, 2)], 16'($urandom));
    repeat ($urandom_range(1, 3)) begin
      send_simple(REQ_RUN, 12'($urandom), 8'($urandom), pick_steps());
      if ($urandom_range(0, 1) == 0)
        send_simple(REQ_READ, pick_cell(), 8'($urandom), 16'($urandom));
    end
    steady_input = 1'b0;
  endtask

  task automatic send_noise();
    tms_in_t item;
    repeat ($urandom_range(1, 3)) begin
      item = random_item(3'($urandom));
      if (item.req_type == REQ_RUN && !machine_halted())
        item.step_count = 16'($urandom_range(0, 25));
      send_request(item);
    end
  endtask

  task automatic test_directed();
    send_simple(REQ_READ, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_READ, 12'hFFF, 8'hFF, 16'hFFFF);
    send_simple(REQ_BAD_FIRST, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_BAD_LAST, 12'hFFF, 8'hFF, 16'hFFFF);
    // empty table: first step hits an undefined entry
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'hFFFF);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'hFFFF);
    send_simple(REQ_RESTART, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_WRITE, 12'hFFF, 8'hFF, 16'd0);
    send_simple(REQ_READ, 12'hFFF, 8'd0, 16'd0);
    send_simple(REQ_WRITE, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_READ, 12'd0, 8'hFF, 16'd0);
    // right move past the tape end, then a run while halted
    send_entry(6'd0, 8'd0, 6'h3F, 8'hFF, 1'b0, 12'd1);
    send_entry(6'h3F, cfg.blank_symbol, 6'h3F, 8'hFF, 1'b0, 12'hFFF);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd1);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd3);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd3);
    send_simple(REQ_RESTART, 12'd0, 8'd0, 16'd0);
    // write, move right, clamp a left move at cell 0, then accept
    send_entry(6'd0, cfg.blank_symbol, 6'd5, 8'h41, 1'b0, 12'd1);
    send_entry(6'd5, cfg.blank_symbol, 6'd5, 8'h42, 1'b1, 12'hFFF);
    send_entry(6'd5, 8'h41, cfg.accept_state, 8'hFF, 1'b0, 12'd0);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd10);
    send_simple(REQ_READ, 12'd1, 8'd0, 16'd0);
    send_simple(REQ_READ, 12'd9, 8'd0, 16'd0);
    send_entry(6'h3F, 8'hFF, 6'd0, 8'd0, 1'b1, 12'd1);
    send_simple(REQ_RESTART, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_WRITE, 12'd0, 8'h42, 16'd0);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd2);
  endtask

  task automatic test_backpressure();
    hold_cycles  = 400;
    steady_input = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) send_simple(REQ_WRITE, pick_cell(), 8'($urandom), 16'($urandom));
      else send_simple(REQ_READ, pick_cell(), 8'($urandom), 16'($urandom));
    end
    steady_input = 1'b0;
    drain_results();
  endtask

  task automatic test_register_extremes();
    // accept equal to reject, blank zero, top initial state
    apply_settings(6'h3F, 6'd0, 6'd0, 8'd0);
    send_simple(REQ_RESTART, 12'd0, 8'd0, 16'd0);
    send_simple(REQ_RUN, 12'd0, 8'd0, 16'd3);
    send_simple(REQ_READ, 12'd0, 8'd0, 16'd0);
    repeat (6) run_program();
    apply_settings(6'd0, 6'h3F, 6'h3E, 8'hFF);
    send_simple(REQ_RESTART, 12'd0, 8'd0, 16'd0);
    repeat (6) run_program();
    apply_settings(INITIAL_RST, ACCEPT_RST, REJECT_RST, BLANK_RST);
  endtask

  task automatic test_random_programs();
    int start;
    logic [5:0] acc_st;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        acc_st = 6'($urandom);
        apply_settings(6'($urandom), acc_st,
                       ($urandom_range(0, 3) == 0) ? acc_st : 6'($urandom), 8'($urandom));
      end
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 9) < 8) run_program();
        else send_noise();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_INITIAL;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    reset_machine_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_register_extremes();
    test_random_programs();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/tms_pkg.sv
sv/tms_table.sv
sv/tms_tape.sv
sv/tms_ctrl.sv
sv/turing_machine_stepper.sv
bench/tb.sv
